/* sv/fpbs_pkg.sv */
// ----------------------------------------------------------------------------
// fpbs_pkg
// Shared types, constants and the microcode program of the band splitter.
// ----------------------------------------------------------------------------
package fpbs_pkg;

  // Fraction bits of the pole state; a sample enters the poles shifted up by this.
  localparam int POLE_FRAC = 16;
  // Input delay per channel for the high band.
  localparam int HIST_TAPS = 3;
  // Width of the low operand of the shared multiplier.
  localparam int MUL_W = 32;

  // Configuration register indexes.
  localparam logic REG_LOW_COEFF  = 1'b0;
  localparam logic REG_HIGH_COEFF = 1'b1;

  // Microcode addressing.
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] S_LOAD    = 4'd0;
  localparam logic [PC_W-1:0] S_DIFF    = 4'd1;
  localparam logic [PC_W-1:0] S_MUL_LO  = 4'd2;
  localparam logic [PC_W-1:0] S_MUL_HI  = 4'd3;
  localparam logic [PC_W-1:0] S_SCALE   = 4'd4;
  localparam logic [PC_W-1:0] S_UPDATE  = 4'd5;
  localparam logic [PC_W-1:0] S_SWITCH  = 4'd6;
  localparam logic [PC_W-1:0] S_OD_LOW  = 4'd7;
  localparam logic [PC_W-1:0] S_OR_LOW  = 4'd8;
  localparam logic [PC_W-1:0] S_OD_HIGH = 4'd9;
  localparam logic [PC_W-1:0] S_OR_HIGH = 4'd10;
  localparam logic [PC_W-1:0] S_OD_MID  = 4'd11;
  localparam logic [PC_W-1:0] S_OR_MID  = 4'd12;
  localparam logic [PC_W-1:0] S_EMIT    = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SCALE,
    OP_UPDATE,
    OP_RELOAD,
    OP_ODIFF,
    OP_ORND,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    OSEL_LOW,
    OSEL_HIGH,
    OSEL_MID
  } osel_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_STAGE_MORE,
    JMP_CHAIN_LOW
  } jump_t;

  typedef enum logic {
    CH_LOW,
    CH_HIGH
  } chain_t;

  typedef struct packed {
    op_t            op;
    osel_t          osel;
    wait_t          waitc;
    jump_t          jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_t    op;
    osel_t  osel;
    chain_t chain;
  } ctrl_t;

  // Handshake status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_ALWAYS, target: S_LOAD};
    case (pc)
      S_LOAD:    w = '{op: OP_LOAD, osel: OSEL_LOW, waitc: WAIT_IN, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_DIFF:    w = '{op: OP_DIFF, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_MUL_LO:  w = '{op: OP_MUL_LO, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_MUL_HI:  w = '{op: OP_MUL_HI, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_SCALE:   w = '{op: OP_SCALE, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_UPDATE:  w = '{op: OP_UPDATE, osel: OSEL_LOW, waitc: WAIT_NONE,
                       jmp: JMP_STAGE_MORE, target: S_DIFF};
      S_SWITCH:  w = '{op: OP_RELOAD, osel: OSEL_LOW, waitc: WAIT_NONE,
                       jmp: JMP_CHAIN_LOW, target: S_DIFF};
      S_OD_LOW:  w = '{op: OP_ODIFF, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_OR_LOW:  w = '{op: OP_ORND, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_OD_HIGH: w = '{op: OP_ODIFF, osel: OSEL_HIGH, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_OR_HIGH: w = '{op: OP_ORND, osel: OSEL_HIGH, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_OD_MID:  w = '{op: OP_ODIFF, osel: OSEL_MID, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_OR_MID:  w = '{op: OP_ORND, osel: OSEL_MID, waitc: WAIT_NONE, jmp: JMP_NEXT,
                       target: S_LOAD};
      S_EMIT:    w = '{op: OP_EMIT, osel: OSEL_LOW, waitc: WAIT_OUT, jmp: JMP_ALWAYS,
                       target: S_LOAD};
      default:   w = '{op: OP_NOP, osel: OSEL_LOW, waitc: WAIT_NONE, jmp: JMP_ALWAYS,
                       target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* sv/fpbs_seq.sv */
// ----------------------------------------------------------------------------
// fpbs_seq
// Microcode sequencer: program counter, pole stage counter and chain select.
// ----------------------------------------------------------------------------
module fpbs_seq #(
  parameter int POLE_STAGES = 4,
  parameter int STG_W       = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  fpbs_pkg::stat_t     stat,
  output fpbs_pkg::ctrl_t     ctrl,
  output logic [STG_W-1:0]    stage,
  output logic                in_ready
);

  logic [fpbs_pkg::PC_W-1:0] pc;
  logic [fpbs_pkg::PC_W-1:0] pc_next;
  logic [STG_W-1:0]          stage_next;
  fpbs_pkg::chain_t          chain;
  fpbs_pkg::chain_t          chain_next;
  fpbs_pkg::uword_t          uw;
  logic                      go;
  logic                      taken;
  logic                      last_stage;

  assign uw         = fpbs_pkg::ucode_word(pc);
  assign last_stage = (stage == STG_W'(POLE_STAGES - 1));
  assign in_ready   = (uw.waitc == fpbs_pkg::WAIT_IN);

  always_comb begin
    case (uw.waitc)
      fpbs_pkg::WAIT_NONE: go = 1'b1;
      fpbs_pkg::WAIT_IN:   go = stat.in_valid;
      fpbs_pkg::WAIT_OUT:  go = stat.out_free;
      default:             go = 1'b1;
    endcase
  end

  always_comb begin
    case (uw.jmp)
      fpbs_pkg::JMP_NEXT:       taken = 1'b0;
      fpbs_pkg::JMP_ALWAYS:     taken = 1'b1;
      fpbs_pkg::JMP_STAGE_MORE: taken = !last_stage;
      fpbs_pkg::JMP_CHAIN_LOW:  taken = (chain == fpbs_pkg::CH_LOW);
      default:                  taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_next    = pc;
    stage_next = stage;
    chain_next = chain;
    if (go) begin
      pc_next = taken ? uw.target : pc + 1'b1;
      case (uw.op)
        fpbs_pkg::OP_LOAD: begin
          stage_next = '0;
          chain_next = fpbs_pkg::CH_LOW;
        end
        fpbs_pkg::OP_UPDATE: begin
          stage_next = last_stage ? '0 : stage + 1'b1;
        end
        fpbs_pkg::OP_RELOAD: begin
          chain_next = fpbs_pkg::CH_HIGH;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= fpbs_pkg::S_LOAD;
      stage <= '0;
      chain <= fpbs_pkg::CH_LOW;
    end else begin
      pc    <= pc_next;
      stage <= stage_next;
      chain <= chain_next;
    end
  end

  // Drop the op while the step waits on a handshake.
  always_comb begin
    ctrl.op    = go ? uw.op : fpbs_pkg::OP_NOP;
    ctrl.osel  = uw.osel;
    ctrl.chain = chain;
  end

endmodule

/* sv/fpbs_dp.sv */
// ----------------------------------------------------------------------------
// fpbs_dp
// Datapath: pole state, input history, shared coefficient multiplier,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module fpbs_dp #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int COEFF_FRAC_BITS = 25,
  parameter int POLE_STAGES     = 4,
  parameter int STG_W           = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fpbs_pkg::ctrl_t                 ctrl,
  input  logic [STG_W-1:0]                stage,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [COEFF_FRAC_BITS+1:0]      cfg_data,
  input  logic                            channel_sel,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_free,
  output logic signed [SAMPLE_WIDTH-1:0]  low_band,
  output logic signed [SAMPLE_WIDTH-1:0]  high_band,
  output logic signed [SAMPLE_WIDTH-1:0]  mid_band
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int PF    = fpbs_pkg::POLE_FRAC;
  localparam int PW    = SW + PF;
  localparam int CF    = COEFF_FRAC_BITS;
  localparam int CW    = CF + 2;
  localparam int MW    = fpbs_pkg::MUL_W;
  localparam int MAG_W = PW + 1;
  localparam int PR_W  = MW + CW;
  localparam int Q_W   = MAG_W + 3;
  localparam int SUM_W = Q_W + 2;
  localparam int OD_W  = PW + 1;
  localparam int RT_W  = PW + 2;
  localparam int RR_W  = RT_W - PF;
  localparam int HT    = fpbs_pkg::HIST_TAPS;
  localparam logic [RT_W-1:0] HALF = RT_W'(1) << (PF - 1);

  // Architectural state
  logic [CW-1:0]          low_coeff;
  logic [CW-1:0]          high_coeff;
  logic signed [PW-1:0]   poles [2][2][POLE_STAGES];
  logic signed [SW-1:0]   hist [2][HT];

  // Working registers
  logic                   ch_r;
  logic signed [SW-1:0]   samp_r;
  logic signed [PW-1:0]   x;
  logic [MAG_W-1:0]       mag;
  logic                   neg;
  logic [PR_W-1:0]        plo;
  logic [PR_W-1:0]        phi;
  logic [Q_W-1:0]         q;
  logic                   qneg;
  logic signed [PW-1:0]   lo_out;
  logic signed [PW-1:0]   hi_out;
  logic signed [OD_W-1:0] od;
  logic signed [SW-1:0]   lo_s;
  logic signed [SW-1:0]   hi_s;
  logic signed [SW-1:0]   mid_s;

  // Combinational
  logic [CW-1:0]          coef;
  logic signed [PW-1:0]   y_cur;
  logic signed [MAG_W-1:0] dxy;
  logic signed [MAG_W-1:0] dyx;
  logic [MW-1:0]          mul_a;
  logic [PR_W-1:0]        prod;
  logic [Q_W-1:0]         q_sum;
  logic signed [SUM_W-1:0] y_ext;
  logic signed [SUM_W-1:0] q_ext;
  logic signed [SUM_W-1:0] upd;
  logic signed [PW-1:0]   ynew;
  logic signed [SW-1:0]   oldest;
  logic signed [PW-1:0]   oldest_p;
  logic signed [OD_W-1:0] od_a;
  logic signed [OD_W-1:0] od_b;
  logic signed [RT_W-1:0] rt;
  logic [RR_W-1:0]        rr;
  logic signed [SW-1:0]   rsat;
  logic                   sx;
  logic                   emit;

  assign emit     = (ctrl.op == fpbs_pkg::OP_EMIT);
  assign out_free = !out_valid || out_ready;

  assign coef     = (ctrl.chain == fpbs_pkg::CH_HIGH) ? high_coeff : low_coeff;
  assign y_cur    = poles[ch_r][ctrl.chain][stage];
  assign oldest   = hist[ch_r][HT-1];
  assign oldest_p = {oldest, {PF{1'b0}}};

  // x - y and y - x side by side; the sign picks the magnitude
  assign dxy = MAG_W'(x) - MAG_W'(y_cur);
  assign dyx = MAG_W'(y_cur) - MAG_W'(x);

  assign mul_a = (ctrl.op == fpbs_pkg::OP_MUL_HI) ? MW'(mag[MAG_W-1:MW]) : mag[MW-1:0];
  assign prod  = PR_W'(mul_a) * PR_W'(coef);

  // Combine the two partial products, round half away on the magnitude
  assign q_sum = (Q_W'(phi) << (MW - CF)) + Q_W'(plo[PR_W-1:CF]) + Q_W'(plo[CF-1]);

  assign y_ext = SUM_W'(y_cur);
  assign q_ext = SUM_W'(q);
  assign upd   = qneg ? (y_ext - q_ext) : (y_ext + q_ext);

  always_comb begin
    if (&upd[SUM_W-1:PW-1] || ~|upd[SUM_W-1:PW-1]) begin
      ynew = upd[PW-1:0];
    end else begin
      ynew = {upd[SUM_W-1], {(PW-1){~upd[SUM_W-1]}}};
    end
  end

  always_comb begin
    case (ctrl.osel)
      fpbs_pkg::OSEL_LOW: begin
        od_a = OD_W'(lo_out);
        od_b = '0;
      end
      fpbs_pkg::OSEL_HIGH: begin
        od_a = OD_W'(oldest_p);
        od_b = OD_W'(hi_out);
      end
      fpbs_pkg::OSEL_MID: begin
        od_a = OD_W'(hi_out);
        od_b = OD_W'(lo_out);
      end
      default: begin
        od_a = '0;
        od_b = '0;
      end
    endcase
  end

  // Ties away from zero: add half, or half minus one below zero, then floor
  assign rt = RT_W'(od) + (od[OD_W-1] ? (HALF - 1'b1) : HALF);
  assign rr = rt[RT_W-1:PF];
  assign sx = rr[RR_W-1];

  always_comb begin
    if (&rr[RR_W-1:SW-1] || ~|rr[RR_W-1:SW-1]) begin
      rsat = rr[SW-1:0];
    end else begin
      rsat = {sx, {(SW-1){~sx}}};
    end
  end

  // Coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      low_coeff  <= '0;
      high_coeff <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fpbs_pkg::REG_LOW_COEFF) begin
        low_coeff <= cfg_data;
      end else begin
        high_coeff <= cfg_data;
      end
    end
  end

  // Channel state: cleared by reset and by any coefficient write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < HT; k++) begin
          hist[c][k] <= '0;
        end
        for (int b = 0; b < 2; b++) begin
          for (int k = 0; k < POLE_STAGES; k++) begin
            poles[c][b][k] <= '0;
          end
        end
      end
    end else begin
      if (ctrl.op == fpbs_pkg::OP_UPDATE) begin
        poles[ch_r][ctrl.chain][stage] <= ynew;
      end
      if (emit) begin
        for (int k = HT - 1; k > 0; k--) begin
          hist[ch_r][k] <= hist[ch_r][k-1];
        end
        hist[ch_r][0] <= samp_r;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      fpbs_pkg::OP_LOAD: begin
        ch_r   <= channel_sel;
        samp_r <= sample_in;
        x      <= {sample_in, {PF{1'b0}}};
      end
      fpbs_pkg::OP_DIFF: begin
        neg <= dxy[MAG_W-1];
        mag <= dxy[MAG_W-1] ? dyx : dxy;
      end
      fpbs_pkg::OP_MUL_LO: begin
        plo <= prod;
      end
      fpbs_pkg::OP_MUL_HI: begin
        phi <= prod;
      end
      fpbs_pkg::OP_SCALE: begin
        q    <= q_sum;
        qneg <= neg;
      end
      fpbs_pkg::OP_UPDATE: begin
        x <= ynew;
        if (stage == STG_W'(POLE_STAGES - 1)) begin
          if (ctrl.chain == fpbs_pkg::CH_HIGH) begin
            hi_out <= ynew;
          end else begin
            lo_out <= ynew;
          end
        end
      end
      fpbs_pkg::OP_RELOAD: begin
        x <= {samp_r, {PF{1'b0}}};
      end
      fpbs_pkg::OP_ODIFF: begin
        od <= od_a - od_b;
      end
      fpbs_pkg::OP_ORND: begin
        case (ctrl.osel)
          fpbs_pkg::OSEL_LOW:  lo_s  <= rsat;
          fpbs_pkg::OSEL_HIGH: hi_s  <= rsat;
          fpbs_pkg::OSEL_MID:  mid_s <= rsat;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      low_band  <= lo_s;
      high_band <= hi_s;
      mid_band  <= mid_s;
    end
  end

endmodule

/* sv/stereo_four_pole_band_splitter.sv */
// ----------------------------------------------------------------------------
// stereo_four_pole_band_splitter
// Stereo three-band crossover built from cascaded one-pole lowpass sections.
// ----------------------------------------------------------------------------
// Each accepted sample runs through the whole microcode program before its
// result is loaded into the output register, and the next sample is accepted
// the cycle after that, so no new sample is taken while one is in flight.
// In the microcode loop every pole of both cascades runs five steps
// (difference, two passes through the single 32-bit coefficient multiplier,
// scaling with rounding, saturated update), followed by six steps that round
// and saturate the three bands. A held result does not block the next sample;
// it only stalls the final step of the following one. A write to either
// coefficient clears both channels' poles and input history in the same
// cycle; write coefficients only while no sample is in flight.
module stereo_four_pole_band_splitter #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int COEFF_FRAC_BITS = 25,
  parameter int POLE_STAGES     = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [COEFF_FRAC_BITS+1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            channel_sel,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  low_band,
  output logic signed [SAMPLE_WIDTH-1:0]  high_band,
  output logic signed [SAMPLE_WIDTH-1:0]  mid_band
);

  localparam int STG_W = (POLE_STAGES > 1) ? $clog2(POLE_STAGES) : 1;

  fpbs_pkg::ctrl_t  ctrl;
  fpbs_pkg::stat_t  stat;
  logic [STG_W-1:0] stage;
  logic             out_free;
  logic             cfg_we;

  // Coefficient writes are taken between samples.
  assign cfg_ready     = in_ready;
  assign cfg_we        = cfg_valid && cfg_ready;
  assign stat.in_valid = in_valid;
  assign stat.out_free = out_free;

  fpbs_seq #(
    .POLE_STAGES (POLE_STAGES),
    .STG_W       (STG_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .ctrl     (ctrl),
    .stage    (stage),
    .in_ready (in_ready)
  );

  fpbs_dp #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .POLE_STAGES     (POLE_STAGES),
    .STG_W           (STG_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stage       (stage),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .channel_sel (channel_sel),
    .sample_in   (sample_in),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_free    (out_free),
    .low_band    (low_band),
    .high_band   (high_band),
    .mid_band    (mid_band)
  );

endmodule

/* bench/band_split_checker.sv */
// ----------------------------------------------------------------------------
// band_split_checker
// Watches the coefficient, sample and band channels of the splitter. It keeps
// its own copy of both coefficients, the per-channel input delay and both pole
// cascades, and predicts the low, high and mid bands of every accepted sample.
// It then compares each band result with the oldest prediction.
// ----------------------------------------------------------------------------
module band_split_checker #(
  parameter int SAMPLE_W   = 24,
  parameter int COEFF_FRAC = 25,
  parameter int STAGES     = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [COEFF_FRAC+1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       channel_sel,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] low_band,
  input  logic signed [SAMPLE_W-1:0] high_band,
  input  logic signed [SAMPLE_W-1:0] mid_band,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POLE_W = SAMPLE_W + fpbs_pkg::POLE_FRAC;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] low;
    logic signed [SAMPLE_W-1:0] high;
    logic signed [SAMPLE_W-1:0] mid;
  } band_set_t;

  logic [COEFF_FRAC+1:0] low_coeff;
  logic [COEFF_FRAC+1:0] high_coeff;
  longint                delay_line[2][fpbs_pkg::HIST_TAPS];
  longint                low_poles[2][STAGES];
  longint                high_poles[2][STAGES];
  band_set_t             band_expect_q[$];
  int                    fail_count;

  function automatic longint clamp(longint v, int w);
    longint top;
    longint bottom;
    top    = (64'sd1 <<< (w - 1)) - 1;
    bottom = -top - 1;
    if (v > top) return top;
    if (v < bottom) return bottom;
    return v;
  endfunction

  // Product with the coefficient, scaled down with rounding half away from zero.
  function automatic longint coeff_scale(longint d, logic [COEFF_FRAC+1:0] c);
    logic [127:0] mag;
    logic [127:0] prod;
    longint       q;
    mag  = (d < 0) ? 128'(-d) : 128'(d);
    prod = mag * c;
    q    = longint'(prod >> COEFF_FRAC);
    if (prod[COEFF_FRAC-1]) q++;
    return (d < 0) ? -q : q;
  endfunction

  // Pole format down to a sample: round half away from zero, then saturate.
  function automatic logic [SAMPLE_W-1:0] pole_to_sample(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (fpbs_pkg::POLE_FRAC - 1))) >>> fpbs_pkg::POLE_FRAC;
    if (v < 0) m = -m;
    m = clamp(m, SAMPLE_W);
    return m[SAMPLE_W-1:0];
  endfunction

  function automatic void clear_channels();
    for (int ch = 0; ch < 2; ch++) begin
      for (int k = 0; k < fpbs_pkg::HIST_TAPS; k++) delay_line[ch][k] = 0;
      for (int k = 0; k < STAGES; k++) begin
        low_poles[ch][k]  = 0;
        high_poles[ch][k] = 0;
      end
    end
  endfunction

  function automatic band_set_t split_sample(logic ch_sel, logic signed [SAMPLE_W-1:0] s);
    band_set_t b;
    longint    x;
    longint    lo_y;
    longint    hi_y;
    longint    oldest;
    int        ch;
    ch     = int'(ch_sel);
    oldest = delay_line[ch][fpbs_pkg::HIST_TAPS-1];
    for (int k = fpbs_pkg::HIST_TAPS - 1; k > 0; k--) delay_line[ch][k] = delay_line[ch][k-1];
    delay_line[ch][0] = longint'(s);
    x    = longint'(s) <<< fpbs_pkg::POLE_FRAC;
    lo_y = x;
    hi_y = x;
    for (int k = 0; k < STAGES; k++) begin
      low_poles[ch][k] = clamp(low_poles[ch][k] + coeff_scale(lo_y - low_poles[ch][k],
                                                              low_coeff), POLE_W);
      lo_y = low_poles[ch][k];
      high_poles[ch][k] = clamp(high_poles[ch][k] + coeff_scale(hi_y - high_poles[ch][k],
                                                                high_coeff), POLE_W);
      hi_y = high_poles[ch][k];
    end
    b.low  = pole_to_sample(lo_y);
    b.high = pole_to_sample((oldest <<< fpbs_pkg::POLE_FRAC) - hi_y);
    b.mid  = pole_to_sample(hi_y - lo_y);
    return b;
  endfunction

  always @(posedge clk) begin
    band_set_t want;
    if (rst) begin
      low_coeff  = '0;
      high_coeff = '0;
      clear_channels();
      band_expect_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpbs_pkg::REG_LOW_COEFF:  low_coeff  = cfg_data;
          fpbs_pkg::REG_HIGH_COEFF: high_coeff = cfg_data;
          default: ;
        endcase
        clear_channels();
      end
      if (out_valid && out_ready) begin
        if (band_expect_q.size() == 0) begin
          $display("%0t: band result with none expected: low %0d high %0d mid %0d",
                   $time, low_band, high_band, mid_band);
          fail_count++;
        end else begin
          want = band_expect_q.pop_front();
          if (low_band !== want.low) begin
            $display("%0t: low_band mismatch: expected %0d, got %0d", $time, want.low,
                     low_band);
            fail_count++;
          end
          if (high_band !== want.high) begin
            $display("%0t: high_band mismatch: expected %0d, got %0d", $time, want.high,
                     high_band);
            fail_count++;
          end
          if (mid_band !== want.mid) begin
            $display("%0t: mid_band mismatch: expected %0d, got %0d", $time, want.mid,
                     mid_band);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) band_expect_q.push_back(split_sample(channel_sel, sample_in));
    end
    // publish after the edge so the stimulus side reads settled counts
    errors  <= fail_count;
    pending <= band_expect_q.size();
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the stereo band splitter through directed extremes and random audio
// under several coefficient settings and idle patterns, and reports the
// verdict from the band checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = 24;
  localparam int COEFF_FRAC = 25;
  localparam int STAGES     = 4;
  localparam int COEFF_W    = COEFF_FRAC + 2;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  localparam logic [COEFF_W-1:0] COEFF_TWO = 27'h4000000;
  localparam logic [COEFF_W-1:0] COEFF_MAX = 27'h7FFFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = fpbs_pkg::REG_LOW_COEFF;
  logic [COEFF_W-1:0]         cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       channel_sel = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] low_band;
  logic signed [SAMPLE_W-1:0] high_band;
  logic signed [SAMPLE_W-1:0] mid_band;

  int errors;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;

  stereo_four_pole_band_splitter #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEFF_FRAC_BITS(COEFF_FRAC),
    .POLE_STAGES(STAGES)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .channel_sel(channel_sel),
    .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .low_band(low_band),
    .high_band(high_band), .mid_band(mid_band)
  );

  band_split_checker #(
    .SAMPLE_W(SAMPLE_W),
    .COEFF_FRAC(COEFF_FRAC),
    .STAGES(STAGES)
  ) checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .channel_sel(channel_sel),
    .sample_in(sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .low_band(low_band),
    .high_band(high_band), .mid_band(mid_band),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 == STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic push_sample(logic ch, logic [SAMPLE_W-1:0] s);
    int gap;
    in_valid    <= 1'b1;
    channel_sel <= ch;
    sample_in   <= s;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    // now and then hold off long enough to land on any microcode step
    if (send_idle != 0 && $urandom_range(19) == 0) gap += $urandom_range(1, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sample channel until every predicted band result is out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_coeff(logic idx, logic [COEFF_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_coeffs(logic [COEFF_W-1:0] lo_c, logic [COEFF_W-1:0] hi_c);
    write_coeff(fpbs_pkg::REG_LOW_COEFF, lo_c);
    write_coeff(fpbs_pkg::REG_HIGH_COEFF, hi_c);
  endtask

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(7))
      0: return '0;
      1: return COEFF_TWO;
      2: return COEFF_MAX;
      3: return COEFF_W'($urandom_range(0, 32'h7FFFFFF));
      default: return COEFF_W'($urandom_range(1, 32'h800000));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'($urandom_range(0, 511)) - 24'd256;
      3, 4: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom_range(0, 2097151)) - 24'd1048576;
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero coefficients after reset: poles hold, high band shows the delay line
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b0, SAMPLE_MIN);
    push_sample(1'b1, 24'd1);
    push_sample(1'b0, 24'hFFFFFF);
    push_sample(1'b0, 24'd0);

    // coefficient of exactly 2.0: bands swing hard and saturate
    set_coeffs(COEFF_TWO, COEFF_TWO);
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b0, SAMPLE_MIN);
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b0, SAMPLE_MIN);
    push_sample(1'b0, SAMPLE_MIN);
    push_sample(1'b1, SAMPLE_MIN);
    push_sample(1'b1, SAMPLE_MAX);

    // coefficient above 2.0 on the high cascade: pole values run into the rails
    set_coeffs('0, COEFF_MAX);
    for (int i = 0; i < 8; i++) push_sample(i[2], i[0] ? SAMPLE_MIN : SAMPLE_MAX);

    set_coeffs(COEFF_MAX, COEFF_W'(1));
    push_sample(1'b1, SAMPLE_MAX);
    push_sample(1'b0, SAMPLE_MIN);
    push_sample(1'b1, 24'h555555);
    push_sample(1'b0, 24'hAAAAAA);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 10;
          recv_idle = 69;
        end
        1: begin
          send_idle = 69;
          recv_idle = 10;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        set_coeffs(pick_coeff(), pick_coeff());
        for (int n = 0; n < 216; n++) push_sample(1'($urandom), pick_sample());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
